@@ hdl/fpa_pkg.sv @@
// Package for the fixed-point ALU: operation codes, default widths and shared helpers.
// No dependencies; every other file imports it.
package fpa_pkg;

   localparam int FRAC_BITS_DEF = 8;
   localparam int WORD_BITS_DEF = 32;
   localparam int PORT_BITS     = 32;
   localparam int KIND_BITS     = 4;

   typedef enum logic [KIND_BITS-1:0] {
      OP_ADD      = 4'd0,
      OP_SUB      = 4'd1,
      OP_MUL      = 4'd2,
      OP_DIV      = 4'd3,
      OP_MAX      = 4'd4,
      OP_MIN      = 4'd5,
      OP_INC      = 4'd6,
      OP_DEC      = 4'd7,
      OP_TO_INT   = 4'd8,
      OP_FROM_INT = 4'd9
   } op_type;

   typedef struct packed {
      logic less;
      logic equal;
      logic greater;
   } cmp_type;

endpackage

@@ hdl/fpa_divider.sv @@
// Pipelined restoring divider for the fixed-point ALU: one quotient bit per stage.
// Depends on fpa_pkg. Carries a tag of side data alongside each item.
module fpa_divider
   import fpa_pkg::*;
#(
   parameter int NUM_BITS = 40,
   parameter int DEN_BITS = 32,
   parameter int TAG_BITS = 8
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   input  logic [NUM_BITS-1:0] in_num,
   input  logic [DEN_BITS-1:0] in_den,
   input  logic [TAG_BITS-1:0] in_tag,
   output logic                out_valid,
   output logic [NUM_BITS-1:0] out_quot,
   output logic [DEN_BITS:0]   out_rem,
   output logic [DEN_BITS-1:0] out_den,
   output logic [TAG_BITS-1:0] out_tag
);

   localparam int STAGES = NUM_BITS;

   logic                valid_ff [1:STAGES];
   logic [NUM_BITS-1:0] quot_ff  [1:STAGES];
   logic [DEN_BITS:0]   rem_ff   [1:STAGES];
   logic [DEN_BITS-1:0] den_ff   [1:STAGES];
   logic [TAG_BITS-1:0] tag_ff   [1:STAGES];

   // The quotient register starts as the numerator and shifts left, taking the
   // new quotient bit in at the bottom while numerator bits leave at the top.
   for (genvar s = 0; s < STAGES; s++) begin : g_stage
      logic                valid_cur;
      logic [NUM_BITS-1:0] quot_cur;
      logic [DEN_BITS:0]   rem_cur;
      logic [DEN_BITS-1:0] den_cur;
      logic [TAG_BITS-1:0] tag_cur;
      logic [DEN_BITS+1:0] trial_in;
      logic [DEN_BITS+1:0] diff_in;

      if (s == 0) begin : g_first
         assign valid_cur = in_valid;
         assign quot_cur  = in_num;
         assign rem_cur   = '0;
         assign den_cur   = in_den;
         assign tag_cur   = in_tag;
      end else begin : g_next
         assign valid_cur = valid_ff[s];
         assign quot_cur  = quot_ff[s];
         assign rem_cur   = rem_ff[s];
         assign den_cur   = den_ff[s];
         assign tag_cur   = tag_ff[s];
      end

      always_comb begin
         trial_in = {rem_cur, quot_cur[NUM_BITS-1]};
         diff_in  = trial_in - {2'b00, den_cur};
      end
      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[s+1] <= 1'b0;
         end else begin
            valid_ff[s+1] <= valid_cur;
         end
         if (diff_in[DEN_BITS+1]) begin
            rem_ff[s+1]  <= trial_in[DEN_BITS:0];
            quot_ff[s+1] <= {quot_cur[NUM_BITS-2:0], 1'b0};
         end else begin
            rem_ff[s+1]  <= diff_in[DEN_BITS:0];
            quot_ff[s+1] <= {quot_cur[NUM_BITS-2:0], 1'b1};
         end
         den_ff[s+1] <= den_cur;
         tag_ff[s+1] <= tag_cur;
      end
   end

   assign out_valid = valid_ff[STAGES];
   assign out_quot  = quot_ff[STAGES];
   assign out_rem   = rem_ff[STAGES];
   assign out_den   = den_ff[STAGES];
   assign out_tag   = tag_ff[STAGES];

endmodule

@@ hdl/fpa_simple.sv @@
// Arithmetic for add, sub, max, min, inc, dec, to_int and from_int.
// Depends on fpa_pkg. Purely combinational; the caller registers the outcome.
module fpa_simple
   import fpa_pkg::*;
#(
   parameter int FRAC_BITS = FRAC_BITS_DEF,
   parameter int WORD_BITS = WORD_BITS_DEF
) (
   input  logic [KIND_BITS-1:0]        kind,
   input  logic signed [WORD_BITS-1:0] a,
   input  logic signed [WORD_BITS-1:0] b,
   output logic signed [WORD_BITS-1:0] value,
   output logic                        ovf
);

   localparam int WIDE = WORD_BITS + FRAC_BITS + 2;
   localparam logic signed [WIDE-1:0] WMAX = (WIDE'(1) <<< (WORD_BITS-1)) - WIDE'(1);
   localparam logic signed [WIDE-1:0] WMIN = -(WIDE'(1) <<< (WORD_BITS-1));

   logic signed [WIDE-1:0] wide;
   logic                   use_sat;

   always_comb begin
      wide    = '0;
      use_sat = 1'b1;
      value   = '0;
      case (kind)
         OP_ADD:      wide = WIDE'(a) + WIDE'(b);
         OP_SUB:      wide = WIDE'(a) - WIDE'(b);
         OP_INC:      wide = WIDE'(a) + WIDE'(1);
         OP_DEC:      wide = WIDE'(a) - WIDE'(1);
         OP_FROM_INT: wide = WIDE'(a) <<< FRAC_BITS;
         OP_MAX: begin
            use_sat = 1'b0;
            value   = (a > b) ? a : b;
         end
         OP_MIN: begin
            use_sat = 1'b0;
            value   = (a < b) ? a : b;
         end
         OP_TO_INT: begin
            use_sat = 1'b0;
            value   = a >>> FRAC_BITS;
         end
         default: use_sat = 1'b0;
      endcase
      ovf = 1'b0;
      if (use_sat) begin
         if (wide > WMAX) begin
            ovf   = 1'b1;
            value = WMAX[WORD_BITS-1:0];
         end else if (wide < WMIN) begin
            ovf   = 1'b1;
            value = WMIN[WORD_BITS-1:0];
         end else begin
            value = wide[WORD_BITS-1:0];
         end
      end
   end

endmodule

@@ hdl/fixed_point_alu.sv @@
// Top level of the fixed-point ALU: input stage, simple ops, multiplier and divider pipes.
// Depends on fpa_pkg, fpa_simple and fpa_divider.
//
// Signed fixed-point ALU with FRAC_BITS fraction bits. An item enters whenever start is high;
// busy is never raised, so one item is taken every cycle. Every item leaves in order, with
// rsp_valid high for one cycle; the receiver cannot stall. The divider settles one quotient
// bit per stage; all other operations are delayed to match it.
module fixed_point_alu
   import fpa_pkg::*;
#(
   parameter int FRAC_BITS = FRAC_BITS_DEF,
   parameter int WORD_BITS = WORD_BITS_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   output logic                        busy,
   input  logic [KIND_BITS-1:0]        req_kind,
   input  logic signed [PORT_BITS-1:0] req_operand_a,
   input  logic signed [PORT_BITS-1:0] req_operand_b,
   output logic                        rsp_valid,
   output logic signed [PORT_BITS-1:0] rsp_result_value,
   output logic                        rsp_a_less,
   output logic                        rsp_a_equal,
   output logic                        rsp_a_greater,
   output logic                        rsp_overflowed,
   output logic                        rsp_divided_by_zero
);

   localparam int W    = WORD_BITS;
   localparam int MAGB = W;                 // magnitude of a word fits W bits unsigned
   localparam int NUMB = W + FRAC_BITS + 1; // 2 * |a| << FRAC_BITS
   localparam int DENB = W + 1;             // 2 * |b|
   localparam int PRODB = 2 * W;
   // tag: kind, neg, b zero, simple value, simple ovf, product result, compare flags
   localparam int TAGB = KIND_BITS + 2 + W + 1 + W + 1 + 3;
   localparam logic [NUMB+1:0] WMAXP = (NUMB+2)'((64'd1 << (W-1)) - 64'd1);
   localparam logic [NUMB+1:0] WMINM = (NUMB+2)'(64'd1 << (W-1));

   assign busy = 1'b0;

   // Stage 1: narrow operands, compare, simple ops, operand magnitudes.
   logic signed [W-1:0] a_in, b_in, simple_value;
   logic                simple_ovf;
   assign a_in = req_operand_a[W-1:0];
   assign b_in = req_operand_b[W-1:0];

   fpa_simple #(.FRAC_BITS(FRAC_BITS), .WORD_BITS(W)) u_simple (
      .kind  (req_kind),
      .a     (a_in),
      .b     (b_in),
      .value (simple_value),
      .ovf   (simple_ovf)
   );

   logic                 s1_valid_ff;
   logic [KIND_BITS-1:0] s1_kind_ff;
   logic [MAGB-1:0]      s1_mag_a_ff, s1_mag_b_ff;
   logic                 s1_neg_ff, s1_bzero_ff, s1_ovf_ff;
   logic [W-1:0]         s1_value_ff;
   cmp_type              s1_cmp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= start;
      end
      s1_kind_ff  <= req_kind;
      s1_mag_a_ff <= a_in[W-1] ? MAGB'(-a_in) : MAGB'(a_in);
      s1_mag_b_ff <= b_in[W-1] ? MAGB'(-b_in) : MAGB'(b_in);
      s1_neg_ff   <= a_in[W-1] ^ b_in[W-1];
      s1_bzero_ff <= (b_in == '0);
      s1_value_ff <= simple_value;
      s1_ovf_ff   <= simple_ovf;
      s1_cmp_ff   <= '{less: a_in < b_in, equal: a_in == b_in, greater: a_in > b_in};
   end

   // Stage 2: magnitude product, registered.
   logic [PRODB-1:0] s2_prod_ff;
   logic             s2_valid_ff;
   logic [KIND_BITS-1:0] s2_kind_ff;
   logic [MAGB-1:0]  s2_mag_a_ff, s2_mag_b_ff;
   logic             s2_neg_ff, s2_bzero_ff, s2_ovf_ff;
   logic [W-1:0]     s2_value_ff;
   cmp_type          s2_cmp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else begin
         s2_valid_ff <= s1_valid_ff;
      end
      s2_prod_ff  <= PRODB'(s1_mag_a_ff) * PRODB'(s1_mag_b_ff);
      s2_kind_ff  <= s1_kind_ff;
      s2_mag_a_ff <= s1_mag_a_ff;
      s2_mag_b_ff <= s1_mag_b_ff;
      s2_neg_ff   <= s1_neg_ff;
      s2_bzero_ff <= s1_bzero_ff;
      s2_value_ff <= s1_value_ff;
      s2_ovf_ff   <= s1_ovf_ff;
      s2_cmp_ff   <= s1_cmp_ff;
   end

   // Stage 3: round and saturate the product; it then rides the divider as tag data.
   logic [PRODB:0]  mul_q;
   logic [W-1:0]    mul_value;
   logic            mul_ovf;
   logic [PRODB:0]  mul_lim;

   always_comb begin
      mul_q   = ({1'b0, s2_prod_ff} + ((PRODB+1)'(1) << (FRAC_BITS-1))) >> FRAC_BITS;
      mul_lim = s2_neg_ff ? (PRODB+1)'(64'd1 << (W-1)) : (PRODB+1)'((64'd1 << (W-1)) - 64'd1);
      mul_ovf = mul_q > mul_lim;
      if (mul_ovf) begin
         mul_value = s2_neg_ff ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
      end else begin
         mul_value = s2_neg_ff ? W'(-mul_q) : W'(mul_q);
      end
   end

   logic [NUMB-1:0] div_num;
   logic [DENB-1:0] div_den;
   logic [TAGB-1:0] div_tag;
   assign div_num = {s2_mag_a_ff, FRAC_BITS'(0), 1'b0};
   assign div_den = {s2_mag_b_ff, 1'b0};
   assign div_tag = {s2_kind_ff, s2_neg_ff, s2_bzero_ff, s2_value_ff, s2_ovf_ff,
                     mul_value, mul_ovf, s2_cmp_ff};

   logic            dv_valid;
   logic [NUMB-1:0] dv_quot;
   logic [DENB:0]   dv_rem;
   logic [DENB-1:0] dv_den;
   logic [TAGB-1:0] dv_tag;

   fpa_divider #(.NUM_BITS(NUMB), .DEN_BITS(DENB), .TAG_BITS(TAGB)) u_div (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (s2_valid_ff),
      .in_num    (div_num),
      .in_den    (div_den),
      .in_tag    (div_tag),
      .out_valid (dv_valid),
      .out_quot  (dv_quot),
      .out_rem   (dv_rem),
      .out_den   (dv_den),
      .out_tag   (dv_tag)
   );

   // Final stage: (2n + d) / 2d rounds up when twice the remainder reaches d,
   // that is when remainder >= |b|.
   logic [KIND_BITS-1:0] t_kind;
   logic                 t_neg, t_bzero, t_sovf, t_movf;
   logic [W-1:0]         t_sval, t_mval;
   cmp_type              t_cmp;
   logic [NUMB+1:0]      div_q;
   logic [W-1:0]         div_value, final_value;
   logic                 div_ovf, final_ovf, final_dz;

   assign {t_kind, t_neg, t_bzero, t_sval, t_sovf, t_mval, t_movf, t_cmp} = dv_tag;

   always_comb begin
      div_q = (NUMB+2)'(dv_quot) +
              (NUMB+2)'((dv_rem >= (DENB+1)'(dv_den[DENB-1:1])) ? 1'b1 : 1'b0);
      div_ovf = div_q > (t_neg ? WMINM : WMAXP);
      if (div_ovf) begin
         div_value = t_neg ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
      end else begin
         div_value = t_neg ? W'(-div_q) : W'(div_q);
      end
      final_dz = 1'b0;
      case (t_kind)
         OP_MUL: begin
            final_value = t_mval;
            final_ovf   = t_movf;
         end
         OP_DIV: begin
            final_dz    = t_bzero;
            final_value = t_bzero ? '0 : div_value;
            final_ovf   = t_bzero ? 1'b0 : div_ovf;
         end
         default: begin
            final_value = t_sval;
            final_ovf   = t_sovf;
         end
      endcase
   end

   logic            out_valid_ff;
   logic [W-1:0]    out_value_ff;
   logic            out_ovf_ff, out_dz_ff;
   cmp_type         out_cmp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= dv_valid;
      end
      out_value_ff <= final_value;
      out_ovf_ff   <= final_ovf;
      out_dz_ff    <= final_dz;
      out_cmp_ff   <= t_cmp;
   end

   assign rsp_valid           = out_valid_ff;
   assign rsp_result_value    = PORT_BITS'($signed(out_value_ff));
   assign rsp_a_less          = out_cmp_ff.less;
   assign rsp_a_equal         = out_cmp_ff.equal;
   assign rsp_a_greater       = out_cmp_ff.greater;
   assign rsp_overflowed      = out_ovf_ff;
   assign rsp_divided_by_zero = out_dz_ff;

endmodule

@@ hdl/fpa_checker.sv @@
// Port-level checker for the fixed-point ALU, bound to the top level.
// Depends on fpa_pkg and fixed_point_alu.
module fpa_checker
   import fpa_pkg::*;
(
   input logic clock,
   input logic reset,
   input logic busy,
   input logic rsp_valid,
   input logic rsp_a_less,
   input logic rsp_a_equal,
   input logic rsp_a_greater,
   input logic rsp_overflowed,
   input logic rsp_divided_by_zero
);

   a_flags_onehot: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $onehot({rsp_a_less, rsp_a_equal, rsp_a_greater}))
      else $error("compare flags not one-hot");

   a_dz_no_ovf: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_divided_by_zero |-> !rsp_overflowed)
      else $error("divide by zero with overflow");

   a_dz_neq: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_divided_by_zero |-> !rsp_a_equal || !rsp_a_less)
      else $error("divide by zero flags inconsistent");

   a_never_busy: assert property (@(posedge clock) !busy)
      else $error("busy raised");

   a_reset_quiet: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result after reset");

endmodule

bind fixed_point_alu fpa_checker u_fpa_checker (
   .clock               (clock),
   .reset               (reset),
   .busy                (busy),
   .rsp_valid           (rsp_valid),
   .rsp_a_less          (rsp_a_less),
   .rsp_a_equal         (rsp_a_equal),
   .rsp_a_greater       (rsp_a_greater),
   .rsp_overflowed      (rsp_overflowed),
   .rsp_divided_by_zero (rsp_divided_by_zero)
);
